FILE: rtl/core/turtle_grid_plotter_assert.svh
// Assertion shorthands used by the plotter sequencer RTL.
// Each expects clk and rst in scope.
`ifndef TURTLE_GRID_PLOTTER_ASSERT_SVH
`define TURTLE_GRID_PLOTTER_ASSERT_SVH

// Same-cycle implication.
`define TGP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tgp_pkg.sv
package tgp_pkg;

  // Default grid edge length in cells
  localparam int GRID_SIZE_DEF = 32;

  // Payload widths
  localparam int MODE_W     = 3;
  localparam int DIST_W     = 6;
  localparam int ROW_BITS_W = 32;
  localparam int ROW_NUM_W  = 5;

  // Command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 3'd0,
    MODE_PEN_UP = 3'd1,
    MODE_PEN_DN = 3'd2,
    MODE_TURN_R = 3'd3,
    MODE_TURN_L = 3'd4,
    MODE_MOVE   = 3'd5,
    MODE_DUMP   = 3'd6
  } mode_t;

  // Headings, clockwise from east
  typedef enum logic [1:0] {
    HEAD_EAST  = 2'd0,
    HEAD_SOUTH = 2'd1,
    HEAD_WEST  = 2'd2,
    HEAD_NORTH = 2'd3
  } heading_t;

  // Grid memory port control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

FILE: rtl/core/tgp_cmd_if.sv
interface tgp_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tgp_pkg::MODE_W-1:0]   mode;
  logic [tgp_pkg::DIST_W-1:0]   distance;

  modport source (output valid, output mode, output distance, input ready);
  modport sink   (input valid, input mode, input distance, output ready);
endinterface

FILE: rtl/core/tgp_row_if.sv
interface tgp_row_if;
  logic                            valid;
  logic                            ready;
  logic [tgp_pkg::ROW_BITS_W-1:0]  row_bits;
  logic [tgp_pkg::ROW_NUM_W-1:0]   row_number;
  logic                            last_row;

  modport source (output valid, output row_bits, output row_number, output last_row,
                  input ready);
  modport sink   (input valid, input row_bits, input row_number, input last_row,
                  output ready);
endinterface

FILE: rtl/core/tgp_grid_mem.sv
module tgp_grid_mem #(
  parameter int GRID_SIZE = tgp_pkg::GRID_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tgp_pkg::mem_ctl_t            ctl,
  input  logic [$clog2(GRID_SIZE)-1:0] addr,
  input  logic [GRID_SIZE-1:0]         wdata,
  output logic [GRID_SIZE-1:0]         rdata
);

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld;
  logic [GRID_SIZE-1:0] rd_q;
  logic                 rd_vld;

  // Per-row written flags; an unwritten row reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (ctl.wr_en) row_vld[addr] <= 1'b1;
      if (ctl.rd_en) rd_vld <= row_vld[addr];
    end
  end

  // Storage with registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[addr] <= wdata;
    if (ctl.rd_en) rd_q <= mem[addr];
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

FILE: rtl/core/tgp_seq.sv
`include "turtle_grid_plotter_assert.svh"

module tgp_seq #(
  parameter int GRID_SIZE = tgp_pkg::GRID_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  tgp_cmd_if.sink                      cmd,
  tgp_row_if.source                    row,
  output tgp_pkg::mem_ctl_t            mem_ctl,
  output logic [$clog2(GRID_SIZE)-1:0] mem_addr,
  output logic [GRID_SIZE-1:0]         mem_wdata,
  input  logic [GRID_SIZE-1:0]         mem_rdata
);

  localparam int RW = $clog2(GRID_SIZE);
  localparam logic [RW-1:0] LAST = RW'(GRID_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_STEP,
    S_MOVE_WR,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  state_t                          state;
  logic                            pen_down;
  tgp_pkg::heading_t               heading;
  logic [RW-1:0]                   pen_row;
  logic [RW-1:0]                   pen_col;
  logic [tgp_pkg::DIST_W-1:0]      steps;
  logic [RW-1:0]                   dump_row;
  logic                            out_valid;
  logic [tgp_pkg::ROW_BITS_W-1:0]  out_bits;
  logic [tgp_pkg::ROW_NUM_W-1:0]   out_num;
  logic                            out_last;

  logic          blocked;
  logic          step_ok;
  logic          out_free;
  logic [RW-1:0] row_next;
  logic [RW-1:0] col_next;

  // Next cell in the current heading, and whether the edge stops us
  always_comb begin
    row_next = pen_row;
    col_next = pen_col;
    blocked  = 1'b0;
    case (heading)
      tgp_pkg::HEAD_EAST: begin
        blocked  = (pen_col == LAST);
        col_next = pen_col + RW'(1);
      end
      tgp_pkg::HEAD_SOUTH: begin
        blocked  = (pen_row == LAST);
        row_next = pen_row + RW'(1);
      end
      tgp_pkg::HEAD_WEST: begin
        blocked  = (pen_col == '0);
        col_next = pen_col - RW'(1);
      end
      tgp_pkg::HEAD_NORTH: begin
        blocked  = (pen_row == '0);
        row_next = pen_row - RW'(1);
      end
      default: blocked = 1'b1;
    endcase
  end

  assign step_ok  = (steps != '0) && !blocked;
  assign out_free = !out_valid || row.ready;

  // Memory port: read the row being stepped into or dumped, write it back modified
  always_comb begin
    mem_ctl.rd_en = ((state == S_MOVE_STEP) && step_ok) || (state == S_DUMP_RD);
    mem_ctl.wr_en = (state == S_MOVE_WR);
    case (state)
      S_MOVE_STEP: mem_addr = row_next;
      S_DUMP_RD:   mem_addr = dump_row;
      default:     mem_addr = pen_row;
    endcase
    mem_wdata          = mem_rdata;
    mem_wdata[pen_col] = pen_down;
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pen_down  <= 1'b0;
      heading   <= tgp_pkg::HEAD_EAST;
      pen_row   <= '0;
      pen_col   <= '0;
      steps     <= '0;
      dump_row  <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop valid after a transfer unless a new row is loaded in the same cycle
      if (row.valid && row.ready && !((state == S_DUMP_OUT) && out_free))
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            case (tgp_pkg::mode_t'(cmd.mode))
              tgp_pkg::MODE_PEN_UP: pen_down <= 1'b0;
              tgp_pkg::MODE_PEN_DN: pen_down <= 1'b1;
              tgp_pkg::MODE_TURN_R: heading  <= tgp_pkg::heading_t'(heading + 2'd1);
              tgp_pkg::MODE_TURN_L: heading  <= tgp_pkg::heading_t'(heading - 2'd1);
              tgp_pkg::MODE_MOVE: begin
                steps <= cmd.distance;
                state <= S_MOVE_STEP;
              end
              tgp_pkg::MODE_DUMP: begin
                dump_row <= '0;
                state    <= S_DUMP_RD;
              end
              default: ;
            endcase
          end
        end
        S_MOVE_STEP: begin
          if (step_ok) begin
            pen_row <= row_next;
            pen_col <= col_next;
            steps   <= steps - tgp_pkg::DIST_W'(1);
            state   <= S_MOVE_WR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MOVE_WR: state <= S_MOVE_STEP;
        S_DUMP_RD: state <= S_DUMP_OUT;
        S_DUMP_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_bits  <= tgp_pkg::ROW_BITS_W'(mem_rdata);
            out_num   <= tgp_pkg::ROW_NUM_W'(dump_row);
            out_last  <= (dump_row == LAST);
            if (dump_row == LAST) begin
              state <= S_IDLE;
            end else begin
              dump_row <= dump_row + RW'(1);
              state    <= S_DUMP_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready      = (state == S_IDLE);
  assign row.valid      = out_valid;
  assign row.row_bits   = out_bits;
  assign row.row_number = out_num;
  assign row.last_row   = out_last;

  `TGP_ASSERT_IMP(a_wr_after_rd, mem_ctl.wr_en, $past(mem_ctl.rd_en), "write without a read")
  `TGP_ASSERT_IMP(a_rd_wr_excl, mem_ctl.rd_en, !mem_ctl.wr_en, "read and write collide")
  `TGP_ASSERT_NEXT(a_pos_hold, state != S_MOVE_STEP, $stable(pen_row) && $stable(pen_col), "pen moved outside a step")
  `TGP_ASSERT_NEXT(a_dump_end, (state == S_DUMP_OUT) && out_free && (dump_row == LAST), (state == S_IDLE) && out_valid && out_last, "dump did not end on the last row")

endmodule

FILE: rtl/core/turtle_grid_plotter.sv
// Turtle plotter: command in, grid row words out on a dump.
// Pen and turn commands complete in the idle state; a move steps cell by cell
// (memory read, then write back) and ends early at the grid edge.
// A dump reads each row and then outputs it, waiting while the output stalls.
// Synchronous reset clears pen, heading, position and per-row written flags;
// the grid reads as all zeros at once, with no clearing pass.
module turtle_grid_plotter #(
  parameter int GRID_SIZE = tgp_pkg::GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tgp_cmd_if.sink     cmd,
  tgp_row_if.source   row
);

  localparam int RW = $clog2(GRID_SIZE);

  tgp_pkg::mem_ctl_t    mem_ctl;
  logic [RW-1:0]        mem_addr;
  logic [GRID_SIZE-1:0] mem_wdata;
  logic [GRID_SIZE-1:0] mem_rdata;

  // Command sequencer and result register
  tgp_seq #(
    .GRID_SIZE (GRID_SIZE)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row       (row),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Grid storage, one word per row
  tgp_grid_mem #(
    .GRID_SIZE (GRID_SIZE)
  ) u_grid (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
